// ----- sv/cts_pkg.sv -----
// ============================================================================
// cts_pkg
// Shared types and constants for the closest-to-target window selector.
// ============================================================================
package cts_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int ERR_WIDTH    = SAMPLE_WIDTH + 1;
  localparam int COUNT_WIDTH  = 16;
  localparam int TIME_WIDTH   = 32;
  localparam int CFG_WIDTH    = 32;
  localparam int CFG_IDX_W    = 2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_TAKE    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 2'd0,
    REG_LIMIT  = 2'd1,
    REG_PERIOD = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic [TIME_WIDTH-1:0]   now_ms;
  } item_t;

  typedef struct packed {
    logic                    done_res;
    logic [SAMPLE_WIDTH-1:0] value;
    logic                    ready_res;
    logic                    holds_sample;
  } result_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } flow_t;

endpackage

// ----- sv/cts_in_stage.sv -----
// ============================================================================
// cts_in_stage
// Input register for requests; holds one request until the core takes it.
// ============================================================================
module cts_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cts_pkg::item_t       item_in,
  input  logic                 advance,
  output cts_pkg::flow_t       flow,
  output cts_pkg::item_t       item_q
);

  logic valid_q;

  assign in_stall     = valid_q && !advance;
  assign flow.valid   = valid_q;
  assign flow.advance = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (!in_stall) begin
      valid_q <= in_valid;
    end
    if (in_valid && !in_stall) begin
      item_q <= item_in;
    end
  end

endmodule

// ----- sv/cts_select_core.sv -----
// ============================================================================
// cts_select_core
// Window state, configuration registers and the per-request update logic.
// ============================================================================
module cts_select_core (
  input  logic                                clk,
  input  logic                                rst,
  input  cts_pkg::flow_t                      flow,
  input  cts_pkg::item_t                      item,
  input  logic                                cfg_valid,
  input  logic [cts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cts_pkg::CFG_WIDTH-1:0]       cfg_data,
  output cts_pkg::result_t                    result
);

  logic signed [cts_pkg::SAMPLE_WIDTH-1:0] target_value;
  logic [cts_pkg::COUNT_WIDTH-1:0]         count_limit;
  logic [cts_pkg::TIME_WIDTH-1:0]          period_length;

  logic [cts_pkg::TIME_WIDTH-1:0]          window_start, window_start_next;
  logic [cts_pkg::SAMPLE_WIDTH-1:0]        best_sample, best_sample_next;
  logic [cts_pkg::ERR_WIDTH-1:0]           best_error, best_error_next;
  logic [cts_pkg::COUNT_WIDTH-1:0]         sample_counter, sample_counter_next;
  logic                                    any_sample, any_sample_next;
  logic                                    ready_flag, ready_flag_next;

  logic signed [cts_pkg::ERR_WIDTH-1:0]    diff;
  logic [cts_pkg::ERR_WIDTH-1:0]           err;
  logic [cts_pkg::TIME_WIDTH-1:0]          elapsed;
  logic                                    expired;
  logic                                    done;
  logic                                    fire;

  assign fire = flow.valid && flow.advance;

  always_comb begin
    diff = $signed({item.sample[cts_pkg::SAMPLE_WIDTH-1], item.sample})
         - $signed({target_value[cts_pkg::SAMPLE_WIDTH-1], target_value});
    err  = diff[cts_pkg::ERR_WIDTH-1] ? cts_pkg::ERR_WIDTH'(-diff) : diff;
  end

  always_comb begin
    window_start_next   = window_start;
    best_sample_next    = best_sample;
    best_error_next     = best_error;
    sample_counter_next = sample_counter;
    any_sample_next     = any_sample;
    ready_flag_next     = ready_flag;
    done                = 1'b0;
    elapsed             = '0;
    expired             = 1'b0;

    case (cts_pkg::op_t'(item.op))
      cts_pkg::OP_PUSH: begin
        if (!any_sample && sample_counter == '0) begin
          window_start_next = item.now_ms;
        end
        if (!any_sample || err < best_error) begin
          best_sample_next = item.sample;
          best_error_next  = err;
        end
        any_sample_next = 1'b1;
        if (sample_counter != cts_pkg::COUNT_MAX) begin
          sample_counter_next = sample_counter + cts_pkg::COUNT_WIDTH'(1'b1);
        end
        elapsed = item.now_ms - window_start_next;
        expired = (count_limit != '0 && sample_counter_next >= count_limit)
               || (period_length != '0 && elapsed >= period_length);
        if (expired) begin
          ready_flag_next = 1'b1;
          done            = 1'b1;
        end
      end
      cts_pkg::OP_TAKE: begin
        if (ready_flag) begin
          done                = 1'b1;
          window_start_next   = window_start + period_length;
          best_sample_next    = '0;
          best_error_next     = '1;
          sample_counter_next = '0;
          any_sample_next     = 1'b0;
          ready_flag_next     = 1'b0;
        end
      end
      cts_pkg::OP_RESTART: begin
        window_start_next   = item.now_ms;
        best_sample_next    = '0;
        best_error_next     = '1;
        sample_counter_next = '0;
        any_sample_next     = 1'b0;
        ready_flag_next     = 1'b0;
      end
      default: begin
      end
    endcase

    result.done_res     = done;
    // a take that delivers reports the best before the take clears the window
    result.value        = (done && item.op == cts_pkg::OP_TAKE) ? best_sample
                                                                : best_sample_next;
    result.ready_res    = ready_flag_next;
    result.holds_sample = any_sample_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_value   <= '0;
      count_limit    <= '0;
      period_length  <= '0;
      window_start   <= '0;
      best_sample    <= '0;
      best_error     <= '1;
      sample_counter <= '0;
      any_sample     <= 1'b0;
      ready_flag     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          cts_pkg::REG_TARGET: target_value  <= cfg_data[cts_pkg::SAMPLE_WIDTH-1:0];
          cts_pkg::REG_LIMIT:  count_limit   <= cfg_data[cts_pkg::COUNT_WIDTH-1:0];
          cts_pkg::REG_PERIOD: period_length <= cfg_data[cts_pkg::TIME_WIDTH-1:0];
          default: begin
          end
        endcase
      end
      if (fire) begin
        window_start   <= window_start_next;
        best_sample    <= best_sample_next;
        best_error     <= best_error_next;
        sample_counter <= sample_counter_next;
        any_sample     <= any_sample_next;
        ready_flag     <= ready_flag_next;
      end
    end
  end

endmodule

// ----- sv/cts_out_stage.sv -----
// ============================================================================
// cts_out_stage
// Result register; loads a new result whenever it is empty or being taken.
// ============================================================================
module cts_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  cts_pkg::result_t   result_in,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output cts_pkg::result_t   result_q
);

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
    if (advance && item_valid) begin
      result_q <= result_in;
    end
  end

endmodule

// ----- sv/closest_to_target_window_select.sv -----
// ============================================================================
// closest_to_target_window_select
// Keeps the sample closest to a target over a window bounded by count and time.
// ============================================================================
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ----------------------------------------
//  in        in_valid / in_stall    op, sample, now_ms
//  out       out_valid / out_stall  done_res, value, ready_res, holds_sample
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One request per cycle while in_stall is low; an accepted request is held
//  in the input register, then its result in the output register until taken.
//  The core updates the window state as each result loads into the output.
//  Synchronous reset clears all window state and configuration.
//  in_stall rises only while a result waits in the output register under
//  out_stall and a request already sits in the input register.
//  cfg_ready is always high.
//
module closest_to_target_window_select (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          op,
  input  logic signed [cts_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic [cts_pkg::TIME_WIDTH-1:0]      now_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                done_res,
  output logic signed [cts_pkg::SAMPLE_WIDTH-1:0] value,
  output logic                                ready_res,
  output logic                                holds_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cts_pkg::CFG_WIDTH-1:0]       cfg_data
);

  cts_pkg::item_t   item_in;
  cts_pkg::item_t   item_q;
  cts_pkg::flow_t   flow;
  cts_pkg::result_t result;
  cts_pkg::result_t result_q;
  logic             advance;

  assign item_in.op     = op;
  assign item_in.sample = sample;
  assign item_in.now_ms = now_ms;
  assign cfg_ready      = 1'b1;

  cts_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .item_in  (item_in),
    .advance  (advance),
    .flow     (flow),
    .item_q   (item_q)
  );

  cts_select_core u_core (
    .clk       (clk),
    .rst       (rst),
    .flow      (flow),
    .item      (item_q),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  cts_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .item_valid (flow.valid),
    .result_in  (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_q   (result_q)
  );

  assign done_res     = result_q.done_res;
  assign value        = result_q.value;
  assign ready_res    = result_q.ready_res;
  assign holds_sample = result_q.holds_sample;

  // a delivering take reports the old best after the window has emptied
  a_empty_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !holds_sample && !done_res |-> value == '0)
    else $error("empty window reported a nonzero value");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_fire_loads_result: assert property (@(posedge clk) disable iff (rst)
    flow.valid && advance |=> out_valid)
    else $error("processed request produced no result");

  a_push_done_has_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res && ready_res |-> holds_sample)
    else $error("expiry reported on an empty window");

endmodule

// ----- verif/tb_closest_to_target_window_select.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_closest_to_target_window_select
// Self-checking bench for the closest-to-target window selector: directed
// corner requests, then randomized windows of pushes, takes and restarts
// under several register settings and idle patterns. Every result is checked
// against an in-bench model of the window state.
// ============================================================================
module tb_closest_to_target_window_select;

  localparam int SAMPLE_WIDTH = cts_pkg::SAMPLE_WIDTH;
  localparam int ERR_WIDTH    = cts_pkg::ERR_WIDTH;
  localparam int COUNT_WIDTH  = cts_pkg::COUNT_WIDTH;
  localparam int TIME_WIDTH   = cts_pkg::TIME_WIDTH;
  localparam int CFG_WIDTH    = cts_pkg::CFG_WIDTH;
  localparam int CFG_IDX_W    = cts_pkg::CFG_IDX_W;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         QUIET_MAX  = 4000;

  logic clk;
  logic rst = 1'b1;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     op = '0;
  logic signed [SAMPLE_WIDTH-1:0] sample = '0;
  logic [TIME_WIDTH-1:0]          now_ms = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           done_res;
  logic signed [SAMPLE_WIDTH-1:0] value;
  logic                           ready_res;
  logic                           holds_sample;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [CFG_WIDTH-1:0]           cfg_data = '0;

  closest_to_target_window_select dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .sample       (sample),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .done_res     (done_res),
    .value        (value),
    .ready_res    (ready_res),
    .holds_sample (holds_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // window model: registers and state
  logic [SAMPLE_WIDTH-1:0] tgt_cfg;
  logic [COUNT_WIDTH-1:0]  lim_cfg;
  logic [TIME_WIDTH-1:0]   per_cfg;
  logic [TIME_WIDTH-1:0]   win_start;
  logic [SAMPLE_WIDTH-1:0] best_val;
  logic [ERR_WIDTH-1:0]    best_err;
  logic [COUNT_WIDTH-1:0]  sample_cnt;
  logic                    win_has;
  logic                    win_ready;

  cts_pkg::item_t   pending_reqs[$];
  cts_pkg::result_t expected_results[$];
  cts_pkg::item_t   next_req;
  cts_pkg::result_t exp_res;

  int idle_in_pct  = 11;
  int idle_out_pct = 88;
  int reqs_queued  = 0;
  int results_done = 0;
  int fail_count   = 0;
  int quiet_cycles = 0;
  logic [TIME_WIDTH-1:0] clk_ms = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void open_window(logic [TIME_WIDTH-1:0] start);
    win_start  = start;
    best_val   = '0;
    best_err   = '1;
    sample_cnt = '0;
    win_has    = 1'b0;
    win_ready  = 1'b0;
  endfunction

  function automatic cts_pkg::result_t predict_window(logic [1:0] opc,
                                                      logic [SAMPLE_WIDTH-1:0] s,
                                                      logic [TIME_WIDTH-1:0] t);
    cts_pkg::result_t             r;
    logic signed [ERR_WIDTH-1:0]  diff;
    logic [ERR_WIDTH-1:0]         err;
    logic [TIME_WIDTH-1:0]        age;
    r = '0;
    case (opc)
      cts_pkg::OP_PUSH: begin
        diff = $signed({s[SAMPLE_WIDTH-1], s}) - $signed({tgt_cfg[SAMPLE_WIDTH-1], tgt_cfg});
        err  = diff[ERR_WIDTH-1] ? -diff : diff;
        if (!win_has && sample_cnt == '0) win_start = t;
        if (!win_has || err < best_err) begin
          best_val = s;
          best_err = err;
        end
        win_has = 1'b1;
        if (sample_cnt != cts_pkg::COUNT_MAX) sample_cnt = sample_cnt + COUNT_WIDTH'(1);
        age = t - win_start;
        if ((lim_cfg != '0 && sample_cnt >= lim_cfg) || (per_cfg != '0 && age >= per_cfg)) begin
          win_ready  = 1'b1;
          r.done_res = 1'b1;
        end
        r.value = best_val;
      end
      cts_pkg::OP_TAKE: begin
        if (win_ready) begin
          r.value    = best_val;
          r.done_res = 1'b1;
          open_window(win_start + per_cfg);
        end else begin
          r.value = win_has ? best_val : '0;
        end
      end
      cts_pkg::OP_RESTART: begin
        open_window(t);
        r.value = '0;
      end
      default: r.value = win_has ? best_val : '0;
    endcase
    r.ready_res    = win_ready;
    r.holds_sample = win_has;
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_window(op, sample, now_ms));
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_in_pct) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          op       <= next_req.op;
          sample   <= next_req.sample;
          now_ms   <= next_req.now_ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(string field, int exp_v, int got_v);
    fail_count++;
    $error("%s: expected %0d, got %0d", field, exp_v, got_v);
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $error("result with no request pending");
        end else begin
          exp_res = expected_results.pop_front();
          results_done++;
          if (done_res !== exp_res.done_res)
            note_mismatch("done_res", exp_res.done_res, done_res);
          if (value !== exp_res.value)
            note_mismatch("value", $signed(exp_res.value), value);
          if (ready_res !== exp_res.ready_res)
            note_mismatch("ready_res", exp_res.ready_res, ready_res);
          if (holds_sample !== exp_res.holds_sample)
            note_mismatch("holds_sample", exp_res.holds_sample, holds_sample);
        end
      end
      out_stall <= $urandom_range(0, 99) < idle_out_pct;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_req(logic [1:0] opc, logic [SAMPLE_WIDTH-1:0] s, logic [TIME_WIDTH-1:0] t);
    pending_reqs.push_back('{op: opc, sample: s, now_ms: t});
    reqs_queued++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (results_done < reqs_queued);
  endtask

  task automatic write_reg(cts_pkg::reg_idx_t idx, logic [CFG_WIDTH-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cts_pkg::REG_TARGET: tgt_cfg = data[SAMPLE_WIDTH-1:0];
      cts_pkg::REG_LIMIT:  lim_cfg = data[COUNT_WIDTH-1:0];
      default:             per_cfg = data;
    endcase
  endtask

  task automatic set_window_cfg(logic [SAMPLE_WIDTH-1:0] tgt, logic [COUNT_WIDTH-1:0] lim,
                                logic [TIME_WIDTH-1:0] per);
    wait_idle();
    repeat (4) @(posedge clk);
    write_reg(cts_pkg::REG_TARGET, {8'($urandom), tgt});
    write_reg(cts_pkg::REG_LIMIT, {16'($urandom), lim});
    write_reg(cts_pkg::REG_PERIOD, per);
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return SAMPLE_WIDTH'($urandom);
      5:       return $urandom_range(0, 1) ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                            : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      default: return tgt_cfg + SAMPLE_WIDTH'($urandom_range(0, 32)) - SAMPLE_WIDTH'(16);
    endcase
  endfunction

  task automatic advance_ms();
    if ($urandom_range(0, 49) == 0)
      clk_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
    else if (per_cfg != '0 && per_cfg < 1000)
      clk_ms = clk_ms + $urandom_range(0, per_cfg / 3 + 1);
    else
      clk_ms = clk_ms + $urandom_range(0, 5);
  endtask

  // mostly well-formed windows (pushes, then a take), some noise and restarts
  task automatic queue_traffic(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 12) begin
        add_req(2'($urandom_range(0, 3)), SAMPLE_WIDTH'($urandom),
                $urandom_range(0, 1) ? TIME_WIDTH'($urandom) : clk_ms);
        left--;
      end else begin
        burst = $urandom_range(1, (lim_cfg != '0 && lim_cfg < 20) ? lim_cfg + 2 : 12);
        repeat (burst) begin
          advance_ms();
          add_req(cts_pkg::OP_PUSH, pick_sample(), clk_ms);
          left--;
        end
        if ($urandom_range(0, 9) < 8) begin
          add_req(cts_pkg::OP_TAKE, SAMPLE_WIDTH'($urandom), TIME_WIDTH'($urandom));
          left--;
        end
        if ($urandom_range(0, 9) == 0) begin
          add_req(cts_pkg::OP_RESTART, SAMPLE_WIDTH'($urandom), clk_ms);
          left--;
        end
      end
    end
  endtask

  task automatic run_phase(int in_pct, int out_pct, logic [SAMPLE_WIDTH-1:0] tgt,
                           logic [COUNT_WIDTH-1:0] lim, logic [TIME_WIDTH-1:0] per);
    set_window_cfg(tgt, lim, per);
    idle_in_pct  = in_pct;
    idle_out_pct = out_pct;
    queue_traffic(100);
    wait_idle();
    queue_traffic(100);
  endtask

  initial begin
    tgt_cfg = '0;
    lim_cfg = '0;
    per_cfg = '0;
    open_window('0);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // count expiry, max error, push after expiry, take ready / not ready
    set_window_cfg(24'h7F_FFFF, 16'd3, 32'd0);
    add_req(OP_UNUSED, 24'h5A_5A5A, 32'h0);
    add_req(cts_pkg::OP_TAKE, 24'h0, 32'h0);
    add_req(cts_pkg::OP_PUSH, 24'h80_0000, 32'd5);
    add_req(cts_pkg::OP_PUSH, 24'h7F_FFFF, 32'd6);
    add_req(cts_pkg::OP_PUSH, 24'h7F_FFFE, 32'd7);
    add_req(cts_pkg::OP_PUSH, 24'h00_0000, 32'd8);
    add_req(cts_pkg::OP_TAKE, 24'hFF_FFFF, 32'hFFFF_FFFF);
    add_req(cts_pkg::OP_TAKE, 24'h0, 32'h0);
    add_req(cts_pkg::OP_RESTART, 24'h0, 32'hFFFF_FFF0);

    // time expiry across the wrap, equal error keeps the first sample
    set_window_cfg(24'h00_0000, 16'd0, 32'd20);
    add_req(cts_pkg::OP_PUSH, 24'h00_0005, 32'hFFFF_FFF8);
    add_req(cts_pkg::OP_PUSH, 24'hFF_FFFB, 32'hFFFF_FFFC);
    add_req(cts_pkg::OP_PUSH, 24'h00_0003, 32'h0000_0005);
    add_req(cts_pkg::OP_PUSH, 24'hFF_FFFE, 32'h0000_000B);
    add_req(cts_pkg::OP_PUSH, 24'h80_0000, 32'h0000_000C);
    add_req(cts_pkg::OP_TAKE, 24'h0, 32'h0);
    add_req(OP_UNUSED, 24'hA5_A5A5, 32'hFFFF_FFFF);
    add_req(cts_pkg::OP_PUSH, 24'h00_0007, 32'h0000_0040);
    add_req(cts_pkg::OP_RESTART, 24'hFF_FFFF, 32'hFFFF_FFFF);
    add_req(cts_pkg::OP_TAKE, 24'h0, 32'h0);

    // longest period: expires only at an age of all ones
    set_window_cfg(24'h80_0000, 16'd0, 32'hFFFF_FFFF);
    add_req(cts_pkg::OP_PUSH, 24'h7F_FFFF, 32'h0000_0100);
    add_req(cts_pkg::OP_PUSH, 24'h80_0000, 32'h0000_00FF);
    add_req(cts_pkg::OP_TAKE, 24'h0, 32'h0);

    run_phase(11, 88, SAMPLE_WIDTH'($urandom), 16'd4, 32'd0);
    run_phase(11, 88, 24'h00_0010, 16'd0, 32'd30);
    run_phase(11, 88, 24'h7F_FFFF, 16'd1, 32'hFFFF_FFFF);
    run_phase(88, 11, 24'h80_0000, 16'hFFFF, 32'd1);
    run_phase(88, 11, SAMPLE_WIDTH'($urandom), 16'd0, 32'd0);
    run_phase(88, 11, SAMPLE_WIDTH'($urandom), 16'($urandom_range(2, 12)),
              32'($urandom_range(5, 60)));
    run_phase(0, 0, SAMPLE_WIDTH'($urandom), 16'd7, 32'd0);
    run_phase(0, 0, SAMPLE_WIDTH'($urandom), 16'd3, 32'd100);
    run_phase(0, 0, 24'h00_0000, 16'd2, 32'd0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cts_pkg.sv
sv/cts_in_stage.sv
sv/cts_select_core.sv
sv/cts_out_stage.sv
sv/closest_to_target_window_select.sv
verif/tb_closest_to_target_window_select.sv
